// ===== src/rle_packbits_encoder_macros.svh =====
// Assertion macros for the run-length packer.
// Taken in by the top level; needs clk and rst_n in the including scope.
`ifndef RLE_PACKBITS_ENCODER_MACROS_SVH
`define RLE_PACKBITS_ENCODER_MACROS_SVH
`ifndef ASSERT_OFF
`define RLE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rle packer check failed");
`define RLE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rle packer check failed");
`else
`define RLE_ASSERT_IMP(label, ante, cons)
`define RLE_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== src/rle_pkg.sv =====
// Shared types and constants of the run-length packer.
// No dependencies; used by every module of the block.
package rle_pkg;

    localparam int LITERAL_MAX = 128;
    localparam int LIT_IDX_W   = $clog2(LITERAL_MAX);
    localparam logic [7:0] LIT_FULL  = 8'(LITERAL_MAX);
    localparam logic [7:0] RUN_MAX   = 8'd130;
    localparam logic [7:0] RUN_MIN   = 8'd3;
    localparam logic [7:0] RUN_TOKEN = 8'h80;
    localparam int LANE_FIELDS = 4;
    localparam int CMDQ_DEPTH  = 4;
    localparam logic [15:0] CAPACITY_RESET = 16'd2032;

    typedef logic [7:0] byte_t;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_FLUSH,
        CMD_RUN,
        CMD_MARK
    } cmd_op_t;

    // arg_a: write address, literal count or run token; arg_b: byte
    typedef struct packed {
        cmd_op_t     op;
        logic [7:0]  arg_a;
        logic [7:0]  arg_b;
        logic        over;
        logic        fin;
        logic        new_over;
        logic [15:0] plen;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    typedef enum logic [3:0] {
        F_IDLE,
        F_EVAL,
        F_ADD,
        F_FIN,
        F_FLUSH_END,
        F_MARK,
        F_CL_START,
        F_CL_LITS,
        F_CL_RUN,
        F_CL_APP,
        F_CL_APP_FL
    } front_state_t;

endpackage

// ===== src/rle_front.sv =====
// Front end: takes input items, tracks runs, literal count and output size,
// and issues commands to the back end. Depends on rle_pkg.
module rle_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            data_byte,
    input  logic                  final_byte,
    input  logic [15:0]           capacity,
    input  rle_pkg::fifo_status_t fifo_st,
    output logic                  cmd_push,
    output rle_pkg::cmd_t         cmd_data
);

    rle_pkg::front_state_t state_reg, state_next;
    rle_pkg::front_state_t ret_reg, ret_next;
    logic        dry_reg, dry_next;
    logic [7:0]  data_reg, data_next;
    logic        fin_reg, fin_next;
    logic [7:0]  run_byte_reg, run_byte_next;
    logic [7:0]  run_len_reg, run_len_next;
    logic [7:0]  lit_cnt_reg, lit_cnt_next;
    logic [15:0] bytes_out_reg, bytes_out_next;
    logic        over_reg, over_next;
    logic [7:0]  close_len_reg, close_len_next;
    logic [1:0]  close_left_reg, close_left_next;
    logic        over_final_reg, over_final_next;
    logic [7:0]  snap_run_byte_reg, snap_run_byte_next;
    logic [7:0]  snap_run_len_reg, snap_run_len_next;
    logic [7:0]  snap_lit_cnt_reg, snap_lit_cnt_next;
    logic [15:0] snap_bytes_out_reg, snap_bytes_out_next;
    logic        snap_over_reg, snap_over_next;

    logic        advance;
    logic        run_open;
    logic        byte_differs;
    logic [7:0]  run_len_inc;
    logic [7:0]  lit_cnt_inc;
    logic [16:0] flush_total;
    logic [16:0] run_total;
    logic        flush_fits;
    logic        run_fits;
    logic        flush_now;

    // dry pass only settles the step's overflow flag, so it never waits
    assign advance      = dry_reg || !fifo_st.full;
    assign run_open     = run_len_reg != 8'd0;
    assign byte_differs = data_reg != run_byte_reg;
    assign run_len_inc  = run_len_reg + 8'd1;
    assign lit_cnt_inc  = lit_cnt_reg + 8'd1;
    assign flush_total  = {1'b0, bytes_out_reg} + 17'd1 + {9'd0, lit_cnt_reg};
    assign run_total    = {1'b0, bytes_out_reg} + 17'd2;
    assign flush_fits   = flush_total <= {1'b0, capacity};
    assign run_fits     = run_total <= {1'b0, capacity};
    assign in_stall     = state_reg != rle_pkg::F_IDLE;

    // next state
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            rle_pkg::F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rle_pkg::F_EVAL;
                end
            end
            rle_pkg::F_EVAL:
            begin
                if (run_open && byte_differs)
                begin
                    state_next = rle_pkg::F_CL_START;
                    ret_next   = rle_pkg::F_ADD;
                end
                else
                begin
                    state_next = rle_pkg::F_ADD;
                end
            end
            rle_pkg::F_ADD:
            begin
                if (run_open && (run_len_inc >= rle_pkg::RUN_MAX))
                begin
                    state_next = rle_pkg::F_CL_START;
                    ret_next   = rle_pkg::F_FIN;
                end
                else
                begin
                    state_next = rle_pkg::F_FIN;
                end
            end
            rle_pkg::F_FIN:
            begin
                if (fin_reg && run_open)
                begin
                    state_next = rle_pkg::F_CL_START;
                    ret_next   = rle_pkg::F_FLUSH_END;
                end
                else if (fin_reg)
                begin
                    state_next = rle_pkg::F_FLUSH_END;
                end
                else
                begin
                    state_next = rle_pkg::F_MARK;
                end
            end
            rle_pkg::F_FLUSH_END:
            begin
                if (advance)
                begin
                    state_next = rle_pkg::F_MARK;
                end
            end
            rle_pkg::F_MARK:
            begin
                if (dry_reg)
                begin
                    state_next = rle_pkg::F_EVAL;
                end
                else if (!fifo_st.full)
                begin
                    state_next = rle_pkg::F_IDLE;
                end
            end
            rle_pkg::F_CL_START:
            begin
                if (run_len_reg >= rle_pkg::RUN_MIN)
                begin
                    state_next = rle_pkg::F_CL_LITS;
                end
                else
                begin
                    state_next = rle_pkg::F_CL_APP;
                end
            end
            rle_pkg::F_CL_LITS:
            begin
                if (advance)
                begin
                    state_next = rle_pkg::F_CL_RUN;
                end
            end
            rle_pkg::F_CL_RUN:
            begin
                if (advance)
                begin
                    state_next = ret_reg;
                end
            end
            rle_pkg::F_CL_APP:
            begin
                if (advance)
                begin
                    if (lit_cnt_inc == rle_pkg::LIT_FULL)
                    begin
                        state_next = rle_pkg::F_CL_APP_FL;
                    end
                    else if (close_left_reg == 2'd1)
                    begin
                        state_next = ret_reg;
                    end
                end
            end
            rle_pkg::F_CL_APP_FL:
            begin
                if (advance)
                begin
                    if (close_left_reg == 2'd0)
                    begin
                        state_next = ret_reg;
                    end
                    else
                    begin
                        state_next = rle_pkg::F_CL_APP;
                    end
                end
            end
            default:
            begin
                state_next = rle_pkg::F_IDLE;
            end
        endcase
    end

    // datapath and command outputs
    always_comb
    begin
        dry_next            = dry_reg;
        data_next           = data_reg;
        fin_next            = fin_reg;
        run_byte_next       = run_byte_reg;
        run_len_next        = run_len_reg;
        lit_cnt_next        = lit_cnt_reg;
        bytes_out_next      = bytes_out_reg;
        over_next           = over_reg;
        close_len_next      = close_len_reg;
        close_left_next     = close_left_reg;
        over_final_next     = over_final_reg;
        snap_run_byte_next  = snap_run_byte_reg;
        snap_run_len_next   = snap_run_len_reg;
        snap_lit_cnt_next   = snap_lit_cnt_reg;
        snap_bytes_out_next = snap_bytes_out_reg;
        snap_over_next      = snap_over_reg;
        flush_now           = 1'b0;
        cmd_push            = 1'b0;
        cmd_data            = '0;
        cmd_data.op         = rle_pkg::CMD_WRITE;
        cmd_data.over       = over_final_reg;

        case (state_reg)
            rle_pkg::F_IDLE:
            begin
                if (in_valid)
                begin
                    data_next           = data_byte;
                    fin_next            = final_byte;
                    dry_next            = 1'b1;
                    snap_run_byte_next  = run_byte_reg;
                    snap_run_len_next   = run_len_reg;
                    snap_lit_cnt_next   = lit_cnt_reg;
                    snap_bytes_out_next = bytes_out_reg;
                    snap_over_next      = over_reg;
                end
            end
            rle_pkg::F_ADD:
            begin
                if (run_open)
                begin
                    run_len_next = run_len_inc;
                end
                else
                begin
                    run_byte_next = data_reg;
                    run_len_next  = 8'd1;
                end
            end
            rle_pkg::F_CL_START:
            begin
                close_len_next  = run_len_reg;
                close_left_next = run_len_reg[1:0];
                run_len_next    = 8'd0;
            end
            rle_pkg::F_CL_LITS,
            rle_pkg::F_FLUSH_END,
            rle_pkg::F_CL_APP_FL:
            begin
                flush_now = advance;
            end
            rle_pkg::F_CL_RUN:
            begin
                if (advance && !over_reg)
                begin
                    if (run_fits)
                    begin
                        cmd_push       = !dry_reg;
                        cmd_data.op    = rle_pkg::CMD_RUN;
                        cmd_data.arg_a = rle_pkg::RUN_TOKEN + (close_len_reg - rle_pkg::RUN_MIN);
                        cmd_data.arg_b = run_byte_reg;
                        bytes_out_next = run_total[15:0];
                    end
                    else
                    begin
                        over_next = 1'b1;
                    end
                end
            end
            rle_pkg::F_CL_APP:
            begin
                if (advance)
                begin
                    cmd_push        = !dry_reg;
                    cmd_data.op     = rle_pkg::CMD_WRITE;
                    cmd_data.arg_a  = 8'(lit_cnt_reg[rle_pkg::LIT_IDX_W-1:0]);
                    cmd_data.arg_b  = run_byte_reg;
                    lit_cnt_next    = lit_cnt_inc;
                    close_left_next = close_left_reg - 2'd1;
                end
            end
            rle_pkg::F_MARK:
            begin
                if (dry_reg)
                begin
                    // rewind to the state at acceptance and replay for real
                    over_final_next = over_reg;
                    dry_next        = 1'b0;
                    run_byte_next   = snap_run_byte_reg;
                    run_len_next    = snap_run_len_reg;
                    lit_cnt_next    = snap_lit_cnt_reg;
                    bytes_out_next  = snap_bytes_out_reg;
                    over_next       = snap_over_reg;
                end
                else if (!fifo_st.full)
                begin
                    cmd_push          = 1'b1;
                    cmd_data.op       = rle_pkg::CMD_MARK;
                    cmd_data.fin      = fin_reg;
                    cmd_data.new_over = over_reg && !snap_over_reg;
                    cmd_data.plen     = over_reg ? 16'd0 : bytes_out_reg;
                    if (fin_reg)
                    begin
                        run_byte_next  = 8'd0;
                        run_len_next   = 8'd0;
                        lit_cnt_next   = 8'd0;
                        bytes_out_next = 16'd0;
                        over_next      = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // literal flush shared by the closing and end-of-block paths
        if (flush_now)
        begin
            lit_cnt_next = 8'd0;
            if ((lit_cnt_reg != 8'd0) && !over_reg)
            begin
                if (flush_fits)
                begin
                    cmd_push       = !dry_reg;
                    cmd_data.op    = rle_pkg::CMD_FLUSH;
                    cmd_data.arg_a = lit_cnt_reg;
                    bytes_out_next = flush_total[15:0];
                end
                else
                begin
                    over_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rle_pkg::F_IDLE;
            ret_reg        <= rle_pkg::F_IDLE;
            dry_reg        <= 1'b0;
            run_byte_reg   <= 8'd0;
            run_len_reg    <= 8'd0;
            lit_cnt_reg    <= 8'd0;
            bytes_out_reg  <= 16'd0;
            over_reg       <= 1'b0;
            close_left_reg <= 2'd0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            dry_reg        <= dry_next;
            run_byte_reg   <= run_byte_next;
            run_len_reg    <= run_len_next;
            lit_cnt_reg    <= lit_cnt_next;
            bytes_out_reg  <= bytes_out_next;
            over_reg       <= over_next;
            close_left_reg <= close_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg           <= data_next;
        fin_reg            <= fin_next;
        close_len_reg      <= close_len_next;
        over_final_reg     <= over_final_next;
        snap_run_byte_reg  <= snap_run_byte_next;
        snap_run_len_reg   <= snap_run_len_next;
        snap_lit_cnt_reg   <= snap_lit_cnt_next;
        snap_bytes_out_reg <= snap_bytes_out_next;
        snap_over_reg      <= snap_over_next;
    end

endmodule

// ===== src/rle_cmd_fifo.sv =====
// Short command queue between front and back end.
// Depends on rle_pkg for the command type and depth.
module rle_cmd_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rle_pkg::cmd_t         push_data,
    input  logic                  pop,
    output rle_pkg::cmd_t         head,
    output rle_pkg::fifo_status_t status
);

    localparam int PTR_W = $clog2(rle_pkg::CMDQ_DEPTH);
    localparam int CNT_W = $clog2(rle_pkg::CMDQ_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_N = CNT_W'(rle_pkg::CMDQ_DEPTH);

    rle_pkg::cmd_t    slot_reg [rle_pkg::CMDQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = count_reg == DEPTH_N;
    assign status.empty = count_reg == '0;
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(rle_pkg::CMDQ_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(rle_pkg::CMDQ_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/rle_back.sv =====
// Back end: holds the literal store, executes queued commands and packs
// output bytes into chunks behind an output register. Depends on rle_pkg.
module rle_back #(
    parameter int OUT_LANES = 4
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  rle_pkg::cmd_t                          head,
    input  rle_pkg::fifo_status_t                  fifo_st,
    output logic                                   pop,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [rle_pkg::LANE_FIELDS-1:0][7:0]   lanes,
    output logic [2:0]                             lane_count,
    output logic                                   step_last,
    output logic                                   stream_done,
    output logic                                   too_big,
    output logic [15:0]                            packed_length
);

    localparam int LANES_USED = (OUT_LANES > rle_pkg::LANE_FIELDS) ? rle_pkg::LANE_FIELDS
                              : ((OUT_LANES < 1) ? 1 : OUT_LANES);
    localparam logic [2:0] LANES_N = 3'(LANES_USED);

    rle_pkg::byte_t lit_mem [rle_pkg::LITERAL_MAX];
    rle_pkg::byte_t rd_data_reg;

    rle_pkg::byte_t acc_reg [rle_pkg::LANE_FIELDS];
    rle_pkg::byte_t acc_next [rle_pkg::LANE_FIELDS];
    logic [2:0]     acc_cnt_reg, acc_cnt_next;
    logic [7:0]     bpos_reg, bpos_next;

    logic                                 out_valid_reg, out_valid_next;
    logic [rle_pkg::LANE_FIELDS-1:0][7:0] lanes_reg, lanes_next;
    logic [2:0]                           lane_count_reg, lane_count_next;
    logic                                 step_last_reg, step_last_next;
    logic                                 stream_done_reg, stream_done_next;
    logic                                 too_big_reg, too_big_next;
    logic [15:0]                          packed_length_reg, packed_length_next;

    logic           have_cmd;
    logic           emit_ok;
    logic           acc_full;
    logic           add_ok;
    logic           need_mark_emit;
    logic           add_byte;
    logic           emit_last;
    logic           emit;
    logic           mem_we;
    logic           rd_en;
    rle_pkg::byte_t byte_in;

    assign have_cmd       = !fifo_st.empty;
    assign emit_ok        = !out_valid_reg || !out_stall;
    assign acc_full       = acc_cnt_reg == LANES_N;
    assign add_ok         = !acc_full || emit_ok;
    assign need_mark_emit = (acc_cnt_reg != 3'd0) || head.fin || head.new_over;
    // a full chunk leaves only once a further byte shows it is not the last
    assign emit           = emit_last || (add_byte && acc_full);

    always_comb
    begin
        case (head.op)
            rle_pkg::CMD_RUN:   byte_in = (bpos_reg == 8'd0) ? head.arg_a : head.arg_b;
            rle_pkg::CMD_FLUSH: byte_in = (bpos_reg == 8'd0) ? head.arg_a - 8'd1 : rd_data_reg;
            default:            byte_in = 8'd0;
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        add_byte  = 1'b0;
        emit_last = 1'b0;
        mem_we    = 1'b0;
        rd_en     = 1'b0;
        bpos_next = bpos_reg;
        if (have_cmd)
        begin
            case (head.op)
                rle_pkg::CMD_WRITE:
                begin
                    mem_we = 1'b1;
                    pop    = 1'b1;
                end
                rle_pkg::CMD_RUN:
                begin
                    if (add_ok)
                    begin
                        add_byte = 1'b1;
                        if (bpos_reg == 8'd0)
                        begin
                            bpos_next = 8'd1;
                        end
                        else
                        begin
                            bpos_next = 8'd0;
                            pop       = 1'b1;
                        end
                    end
                end
                rle_pkg::CMD_FLUSH:
                begin
                    // token first, then one stored literal per cycle while the output can take it
                    if (add_ok)
                    begin
                        add_byte = 1'b1;
                        rd_en    = 1'b1;
                        if (bpos_reg == head.arg_a)
                        begin
                            bpos_next = 8'd0;
                            pop       = 1'b1;
                        end
                        else
                        begin
                            bpos_next = bpos_reg + 8'd1;
                        end
                    end
                end
                rle_pkg::CMD_MARK:
                begin
                    if (!need_mark_emit)
                    begin
                        pop = 1'b1;
                    end
                    else if (emit_ok)
                    begin
                        pop       = 1'b1;
                        emit_last = 1'b1;
                    end
                end
                default:
                begin
                    pop = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        for (int j = 0; j < rle_pkg::LANE_FIELDS; j++)
        begin
            acc_next[j] = acc_reg[j];
        end
        acc_cnt_next = acc_cnt_reg;
        if (emit_last)
        begin
            acc_cnt_next = 3'd0;
        end
        else if (add_byte)
        begin
            if (acc_full)
            begin
                acc_next[0]  = byte_in;
                acc_cnt_next = 3'd1;
            end
            else
            begin
                for (int j = 0; j < rle_pkg::LANE_FIELDS; j++)
                begin
                    if (3'(j) == acc_cnt_reg)
                    begin
                        acc_next[j] = byte_in;
                    end
                end
                acc_cnt_next = acc_cnt_reg + 3'd1;
            end
        end
    end

    always_comb
    begin
        out_valid_next     = out_valid_reg && out_stall;
        lanes_next         = lanes_reg;
        lane_count_next    = lane_count_reg;
        step_last_next     = step_last_reg;
        stream_done_next   = stream_done_reg;
        too_big_next       = too_big_reg;
        packed_length_next = packed_length_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            for (int j = 0; j < rle_pkg::LANE_FIELDS; j++)
            begin
                lanes_next[j] = (3'(j) < acc_cnt_reg) ? acc_reg[j] : 8'd0;
            end
            lane_count_next    = acc_cnt_reg;
            step_last_next     = emit_last;
            stream_done_next   = emit_last && head.fin;
            too_big_next       = head.over;
            packed_length_next = (emit_last && head.fin) ? head.plen : 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            acc_cnt_reg   <= 3'd0;
            bpos_reg      <= 8'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            acc_cnt_reg   <= acc_cnt_next;
            bpos_reg      <= bpos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < rle_pkg::LANE_FIELDS; j++)
        begin
            acc_reg[j] <= acc_next[j];
        end
        lanes_reg         <= lanes_next;
        lane_count_reg    <= lane_count_next;
        step_last_reg     <= step_last_next;
        stream_done_reg   <= stream_done_next;
        too_big_reg       <= too_big_next;
        packed_length_reg <= packed_length_next;
    end

    // literal store: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lit_mem[head.arg_a[rle_pkg::LIT_IDX_W-1:0]] <= head.arg_b;
        end
        if (rd_en)
        begin
            rd_data_reg <= lit_mem[bpos_reg[rle_pkg::LIT_IDX_W-1:0]];
        end
    end

    assign out_valid     = out_valid_reg;
    assign lanes         = lanes_reg;
    assign lane_count    = lane_count_reg;
    assign step_last     = step_last_reg;
    assign stream_done   = stream_done_reg;
    assign too_big       = too_big_reg;
    assign packed_length = packed_length_reg;

endmodule

// ===== src/rle_packbits_encoder.sv =====
// Run-length packer top. An item is taken only while the front end is idle; the front
// walks each byte twice (sizing pass, then command pass), and the command pass also waits
// while the queue is full, so a new item is taken only once the last one is through.
// Commands queue four deep; the back end packs one byte per cycle while the output is not
// stalled, and registers a step's last chunk once its mark reaches the queue head and the output can take it.
// rst_n clears all control state and sets capacity_reg to 2032; the literal store is not.
`include "rle_packbits_encoder_macros.svh"

module rle_packbits_encoder #(
    parameter int OUT_LANES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  lane_0,
    output logic [7:0]  lane_1,
    output logic [7:0]  lane_2,
    output logic [7:0]  lane_3,
    output logic [2:0]  lane_count,
    output logic        step_last,
    output logic        stream_done,
    output logic        too_big,
    output logic [15:0] packed_length
);

    logic [15:0]                          capacity_reg, capacity_next;
    logic                                 cfg_write;
    logic                                 q_push;
    logic                                 q_pop;
    rle_pkg::cmd_t                        q_in;
    rle_pkg::cmd_t                        q_head;
    rle_pkg::fifo_status_t                fifo_st;
    logic [rle_pkg::LANE_FIELDS-1:0][7:0] lanes;

    // only word 0 is implemented; the other word reads as zero
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && !paddr[2];
    assign prdata    = paddr[2] ? 32'd0 : {16'd0, capacity_reg};

    always_comb
    begin
        capacity_next = capacity_reg;
        if (cfg_write)
        begin
            capacity_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= rle_pkg::CAPACITY_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    rle_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .capacity   (capacity_reg),
        .fifo_st    (fifo_st),
        .cmd_push   (q_push),
        .cmd_data   (q_in)
    );

    rle_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .status    (fifo_st)
    );

    rle_back #(
        .OUT_LANES (OUT_LANES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (q_head),
        .fifo_st       (fifo_st),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .lanes         (lanes),
        .lane_count    (lane_count),
        .step_last     (step_last),
        .stream_done   (stream_done),
        .too_big       (too_big),
        .packed_length (packed_length)
    );

    assign lane_0 = lanes[0];
    assign lane_1 = lanes[1];
    assign lane_2 = lanes[2];
    assign lane_3 = lanes[3];

    `RLE_ASSERT_IMP(a_no_push_when_full, q_push, !fifo_st.full)
    `RLE_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    `RLE_ASSERT_IMP(a_empty_chunk_is_last, out_valid && (lane_count == 3'd0), step_last)
    `RLE_ASSERT_IMP(a_length_only_at_end, out_valid && (|packed_length), stream_done && !too_big)

endmodule

// ===== bench/rle_packbits_encoder_tb.sv =====
// Self-checking bench for the run-length packer: byte items in, packed chunks out.
// Needs rle_pkg and rle_packbits_encoder; a local packing predictor checks every chunk.
module rle_packbits_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LANES = 4;
    localparam logic [2:0] ADDR_CAPACITY = 3'd0;
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES = 1500;
    localparam int RANDOM_BYTES = 180;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [7:0] b;
        logic       fin;
        logic       wait_idle;
    } raw_item_t;

    typedef struct packed {
        logic [LANES-1:0][7:0] lanes;
        logic [2:0]            count;
        logic                  last;
        logic                  done;
        logic                  big;
        logic [15:0]           plen;
    } chunk_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    typedef enum logic [1:0] {
        SEG_RUN,
        SEG_LITERAL,
        SEG_NOISE
    } seg_kind_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = '0;
    logic        final_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  lane_0, lane_1, lane_2, lane_3;
    logic [2:0]  lane_count;
    logic        step_last;
    logic        stream_done;
    logic        too_big;
    logic [15:0] packed_length;

    rle_packbits_encoder dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .data_byte(data_byte), .final_byte(final_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .lane_0(lane_0), .lane_1(lane_1), .lane_2(lane_2), .lane_3(lane_3),
        .lane_count(lane_count), .step_last(step_last), .stream_done(stream_done),
        .too_big(too_big), .packed_length(packed_length)
    );

    // packing predictor state
    logic [7:0]  lit_buf [rle_pkg::LITERAL_MAX];
    int          lit_cnt = 0;
    logic [7:0]  run_val = '0;
    int          run_len = 0;
    logic [15:0] packed_total = '0;
    bit          cap_exceeded = 1'b0;
    logic [15:0] capacity = rle_pkg::CAPACITY_RESET;
    logic [7:0]  step_bytes [$];

    raw_item_t   raw_bytes_q [$];
    chunk_t      expected_chunks [$];
    int          chunks_due = 0;
    int          chunks_seen = 0;
    int          errors = 0;
    int          cycles = 0;
    int          bytes_sent = 0;
    int          blocks_sent = 0;
    int          blocks_refused = 0;
    int          settings_used = 0;
    int          random_bytes = 0;
    int          hold_asked = 0;
    int          hold_given = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_left = 0;
    int          seg_left = 0;
    rx_mode_t    rx_mode = RX_FREE;

    initial forever #6 clk = ~clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s at chunk %0d: got 0x%0h, expected 0x%0h",
                 what, chunks_seen, got, want);
        errors++;
    endtask

    function automatic void spill_literals();
        int n;
        n = lit_cnt;
        lit_cnt = 0;
        if (n == 0 || cap_exceeded)
            return;
        if (int'(packed_total) + 1 + n > int'(capacity))
        begin
            cap_exceeded = 1'b1;
            return;
        end
        step_bytes.push_back(8'(n - 1));
        for (int i = 0; i < n; i++)
            step_bytes.push_back(lit_buf[i]);
        packed_total = 16'(int'(packed_total) + 1 + n);
    endfunction

    function automatic void put_run_token(input int len, input logic [7:0] v);
        if (cap_exceeded)
            return;
        if (int'(packed_total) + 2 > int'(capacity))
        begin
            cap_exceeded = 1'b1;
            return;
        end
        step_bytes.push_back(rle_pkg::RUN_TOKEN + 8'(len - int'(rle_pkg::RUN_MIN)));
        step_bytes.push_back(v);
        packed_total = packed_total + 16'd2;
    endfunction

    function automatic void retire_run();
        int len;
        len = run_len;
        run_len = 0;
        if (len >= int'(rle_pkg::RUN_MIN))
        begin
            spill_literals();
            put_run_token(len, run_val);
        end
        else
        begin
            // short runs go to the literal buffer, which spills when full
            for (int i = 0; i < len; i++)
            begin
                lit_buf[lit_cnt % rle_pkg::LITERAL_MAX] = run_val;
                lit_cnt++;
                if (lit_cnt >= rle_pkg::LITERAL_MAX)
                    spill_literals();
            end
        end
    endfunction

    function automatic void pack_byte(input logic [7:0] b, input logic fin);
        bit     was_over;
        bit     over_now;
        int     nres;
        int     pos;
        chunk_t c;
        was_over = cap_exceeded;
        step_bytes.delete();
        if (run_len > 0 && b != run_val)
            retire_run();
        if (run_len == 0)
        begin
            run_val = b;
            run_len = 1;
        end
        else
            run_len++;
        if (run_len >= int'(rle_pkg::RUN_MAX))
            retire_run();
        if (fin)
        begin
            if (run_len > 0)
                retire_run();
            spill_literals();
        end
        over_now = cap_exceeded;
        nres = (step_bytes.size() + LANES - 1) / LANES;
        // an empty step still reports at the end of a block or on first overflow
        if (nres == 0 && (fin || (over_now && !was_over)))
            nres = 1;
        pos = 0;
        for (int k = 0; k < nres; k++)
        begin
            c = '0;
            for (int j = 0; j < LANES; j++)
            begin
                if (pos < step_bytes.size())
                begin
                    c.lanes[j] = step_bytes[pos];
                    pos++;
                    c.count = c.count + 3'd1;
                end
            end
            c.last = (k == nres - 1);
            c.done = fin && c.last;
            c.big  = over_now;
            c.plen = (c.done && !over_now) ? packed_total : 16'd0;
            expected_chunks.push_back(c);
        end
        chunks_due += nres;
        if (fin)
        begin
            lit_cnt = 0;
            run_val = '0;
            run_len = 0;
            packed_total = '0;
            cap_exceeded = 1'b0;
        end
    endfunction

    // sender: bursts of items with random gaps; an item may wait for the block to drain
    always @(posedge clk)
    begin
        logic      nxt_valid;
        raw_item_t cur;
        if (rst_n)
        begin
            nxt_valid = in_valid;
            if (in_valid && !in_stall)
            begin
                cur = raw_bytes_q.pop_front();
                pack_byte(cur.b, cur.fin);
                bytes_sent++;
                if (cur.fin)
                    blocks_sent++;
                nxt_valid = 1'b0;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
                end
                else
                    burst_left--;
            end
            if (!nxt_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (raw_bytes_q.size() > 0 &&
                         !(raw_bytes_q[0].wait_idle && chunks_seen != chunks_due))
                begin
                    nxt_valid = 1'b1;
                    data_byte <= raw_bytes_q[0].b;
                    final_byte <= raw_bytes_q[0].fin;
                end
            end
            in_valid <= nxt_valid;
        end
    end

    // receiver stall pattern, with an occasional long hold-off on request
    always @(posedge clk)
    begin
        logic nxt;
        if (hold_given != hold_asked)
        begin
            hold_left = HOLD_CYCLES;
            hold_given = hold_asked;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            nxt = 1'b1;
        end
        else
        begin
            if (seg_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                seg_left = $urandom_range(20, 200);
            end
            seg_left--;
            case (rx_mode)
                RX_FREE:     nxt = 1'b0;
                RX_LIGHT:    nxt = ($urandom_range(0, 3) == 0);
                RX_HEAVY:    nxt = ($urandom_range(0, 9) < 7);
                RX_PERIODIC: nxt = ((seg_left % 5) < 2);
                default:     nxt = 1'b0;
            endcase
        end
        out_stall <= nxt;
    end

    // chunk checker
    always @(posedge clk)
    begin
        chunk_t exp_c;
        logic [LANES-1:0][7:0] got_lanes;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_chunks.size() == 0)
                report_mismatch("chunk with nothing expected", 1, 0);
            else
            begin
                exp_c = expected_chunks.pop_front();
                got_lanes = {lane_3, lane_2, lane_1, lane_0};
                for (int j = 0; j < LANES; j++)
                    if (got_lanes[j] !== exp_c.lanes[j])
                        report_mismatch($sformatf("lane_%0d", j),
                                        int'(got_lanes[j]), int'(exp_c.lanes[j]));
                if (lane_count !== exp_c.count)
                    report_mismatch("lane_count", int'(lane_count), int'(exp_c.count));
                if (step_last !== exp_c.last)
                    report_mismatch("step_last", int'(step_last), int'(exp_c.last));
                if (stream_done !== exp_c.done)
                    report_mismatch("stream_done", int'(stream_done), int'(exp_c.done));
                if (too_big !== exp_c.big)
                    report_mismatch("too_big", int'(too_big), int'(exp_c.big));
                if (packed_length !== exp_c.plen)
                    report_mismatch("packed_length", int'(packed_length), int'(exp_c.plen));
                if (exp_c.done && exp_c.big)
                    blocks_refused++;
                chunks_seen <= chunks_seen + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d chunks outstanding",
                     cycles, expected_chunks.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic add_item(input logic [7:0] b, input logic fin, input logic hold = 1'b0);
        raw_item_t it;
        it.b = b;
        it.fin = fin;
        it.wait_idle = hold;
        raw_bytes_q.push_back(it);
    endtask

    task automatic add_run(input logic [7:0] b, input int n, input logic fin_last);
        for (int i = 0; i < n; i++)
            add_item(b, fin_last && (i == n - 1));
    endtask

    // wait until the block has nothing in flight, then let it go quiet
    task automatic settle_block();
        while (raw_bytes_q.size() != 0 || in_valid || expected_chunks.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cap_write(input logic [15:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_CAPACITY;
        pwdata <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        capacity = value;
        settings_used++;
        @(negedge clk);
    endtask

    task automatic gen_block(input bit big, input bit hold_first);
        logic [7:0] s [$];
        logic [7:0] v;
        int         n;
        int         r;
        int         segs;
        seg_kind_t  kind;
        if (big)
        begin
            // fills the literal buffer past its limit, then a short run and a tail
            n = $urandom_range(129, 132);
            for (int i = 0; i < n; i++)
            begin
                do
                    v = 8'($urandom);
                while (s.size() > 0 && v == s[s.size() - 1]);
                s.push_back(v);
            end
            v = 8'($urandom);
            n = $urandom_range(3, 8);
            for (int i = 0; i < n; i++)
                s.push_back(v);
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                s.push_back(8'($urandom));
        end
        else
        begin
            segs = $urandom_range(1, 5);
            for (int g = 0; g < segs; g++)
            begin
                kind = seg_kind_t'($urandom_range(0, 2));
                case (kind)
                    SEG_RUN:
                    begin
                        v = 8'($urandom);
                        r = $urandom_range(0, 99);
                        n = (r < 35) ? $urandom_range(1, 2) :
                            (r < 55) ? 3 :
                            (r < 85) ? $urandom_range(4, 12) :
                            (r < 95) ? $urandom_range(13, 40) : $urandom_range(128, 131);
                        for (int i = 0; i < n; i++)
                            s.push_back(v);
                    end
                    SEG_LITERAL:
                    begin
                        n = $urandom_range(1, 12);
                        for (int i = 0; i < n; i++)
                        begin
                            do
                                v = 8'($urandom);
                            while (s.size() > 0 && v == s[s.size() - 1]);
                            s.push_back(v);
                        end
                    end
                    default:
                    begin
                        // small alphabet: three byte values, which form short runs by chance
                        n = $urandom_range(1, 16);
                        for (int i = 0; i < n; i++)
                        begin
                            r = $urandom_range(0, 2);
                            s.push_back((r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'h5A);
                        end
                    end
                endcase
            end
        end
        for (int i = 0; i < s.size(); i++)
            add_item(s[i], i == s.size() - 1, hold_first && i == 0);
        random_bytes += s.size();
    endtask

    initial
    begin
        int nb;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset capacity: min run, short runs into literals, single byte, run at end
        add_item(8'h00, 1'b0);
        add_run(8'hFF, 3, 1'b0);
        add_run(8'h55, 2, 1'b0);
        add_item(8'hAA, 1'b0);
        add_item(8'h01, 1'b1);
        add_item(8'h80, 1'b1);
        add_run(8'h7F, 4, 1'b1);
        settle_block();

        // smallest capacity: overflow at the end, and mid-block then silent to the end
        cap_write(16'd2);
        add_item(8'h10, 1'b0);
        add_item(8'h20, 1'b1);
        add_run(8'h33, 3, 1'b0);
        add_item(8'h44, 1'b1);
        add_run(8'h01, 3, 1'b0);
        add_run(8'h02, 3, 1'b0);
        add_item(8'h03, 1'b1);
        settle_block();

        // capacity below range
        cap_write(16'd0);
        add_item(8'h9A, 1'b1);
        settle_block();

        // full literal buffer while the receiver holds off
        cap_write(16'hFFFF);
        hold_asked++;
        gen_block(1'b1, 1'b0);
        gen_block(1'b0, 1'b1);
        settle_block();

        while (random_bytes < RANDOM_BYTES)
        begin
            case ($urandom_range(0, 4))
                0:       cap_write(16'hFFFF);
                1:       cap_write(16'd2);
                2:       cap_write(16'($urandom_range(3, 40)));
                3:       cap_write(16'($urandom_range(41, 400)));
                default: cap_write(rle_pkg::CAPACITY_RESET);
            endcase
            nb = $urandom_range(1, 3);
            for (int k = 0; k < nb; k++)
                gen_block(1'b0, k > 0 && $urandom_range(0, 1) == 1);
            settle_block();
        end

        if (expected_chunks.size() != 0)
            report_mismatch("chunks still expected", expected_chunks.size(), 0);
        $display("sent %0d bytes in %0d blocks under %0d capacity settings in %0d cycles",
                 bytes_sent, blocks_sent, settings_used, cycles);
        $display("checked %0d chunks; %0d blocks refused as too big; one %0d-cycle hold-off",
                 chunks_seen, blocks_refused, HOLD_CYCLES);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
